// ----- hdl/rwx_pkg.sv -----
`default_nettype none
package rwx_pkg;

    localparam int MOD_BITS_DEF = 20;
    localparam int VAL_W        = 20;
    localparam int EXP_W        = 20;
    localparam int KEY_W        = 8;
    localparam int CMD_W        = 2;
    localparam int CFG_IDX_W    = 2;

    // command and result kind codes
    localparam logic [CMD_W-1:0] CMD_WRAP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNWRAP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA   = 2'd2;

    localparam logic [CMD_W-1:0] KIND_WRAPPED   = 2'd0;
    localparam logic [CMD_W-1:0] KIND_RECOVERED = 2'd1;
    localparam logic [CMD_W-1:0] KIND_DATA      = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENC_EXP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_EXP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SESSION_KEY = 2'd3;

    // microprogram addresses
    typedef enum logic [3:0] {
        UP_IDLE  = 4'd0,
        UP_RED   = 4'd1,
        UP_RED_W = 4'd2,
        UP_TEST  = 4'd3,
        UP_TESTB = 4'd4,
        UP_MUL   = 4'd5,
        UP_MUL_W = 4'd6,
        UP_SQ    = 4'd7,
        UP_SQ_W  = 4'd8,
        UP_DONE  = 4'd9
    } t_pc;

    typedef enum logic [1:0] {
        MSEL_RED,
        MSEL_ACC,
        MSEL_SQR
    } t_msel;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_BASE,
        DST_ACC
    } t_dest;

    typedef enum logic [1:0] {
        J_NEXT,
        J_ALWAYS,
        J_EXP_ZERO,
        J_EXP_EVEN
    } t_jcond;

    typedef struct packed {
        logic   dispatch;
        logic   mstart;
        t_msel  msel;
        logic   mwait;
        t_dest  dest;
        logic   exp_shift;
        t_jcond jcond;
        t_pc    target;
        logic   emit;
    } t_uword;

    localparam t_uword UW_NOP = '{
        dispatch: 1'b0, mstart: 1'b0, msel: MSEL_RED, mwait: 1'b0, dest: DST_NONE,
        exp_shift: 1'b0, jcond: J_NEXT, target: UP_IDLE, emit: 1'b0
    };

    // control store: square-and-multiply, least significant exponent bit first
    function automatic t_uword ucode(input t_pc pc);
        t_uword uw;
        uw = UW_NOP;
        case (pc)
            UP_IDLE: begin
                uw.dispatch = 1'b1;
            end
            UP_RED: begin
                uw.mstart = 1'b1;
                uw.msel   = MSEL_RED;
            end
            UP_RED_W: begin
                uw.mwait = 1'b1;
                uw.dest  = DST_BASE;
            end
            UP_TEST: begin
                uw.jcond  = J_EXP_ZERO;
                uw.target = UP_DONE;
            end
            UP_TESTB: begin
                uw.jcond  = J_EXP_EVEN;
                uw.target = UP_SQ;
            end
            UP_MUL: begin
                uw.mstart = 1'b1;
                uw.msel   = MSEL_ACC;
            end
            UP_MUL_W: begin
                uw.mwait = 1'b1;
                uw.dest  = DST_ACC;
            end
            UP_SQ: begin
                uw.mstart = 1'b1;
                uw.msel   = MSEL_SQR;
            end
            UP_SQ_W: begin
                uw.mwait     = 1'b1;
                uw.dest      = DST_BASE;
                uw.exp_shift = 1'b1;
                uw.jcond     = J_ALWAYS;
                uw.target    = UP_TEST;
            end
            UP_DONE: begin
                uw.emit   = 1'b1;
                uw.jcond  = J_ALWAYS;
                uw.target = UP_IDLE;
            end
            default: begin
                uw.jcond  = J_ALWAYS;
                uw.target = UP_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rwx_if.sv -----
`default_nettype none
interface rwx_in_if
    import rwx_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface rwx_out_if
    import rwx_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] kind;
    logic [VAL_W-1:0] result_value;

    modport source (output valid, output kind, output result_value, input ready);
    modport sink   (input valid, input kind, input result_value, output ready);
endinterface

interface rwx_cfg_if
    import rwx_pkg::*;
#(
    parameter int DATA_W = VAL_W
);
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/rsa_wrapped_xor_cipher.sv -----
`default_nettype none
// channel  | dir | handshake   | payload
// i_in     | in  | valid/ready | cmd[1:0], value[19:0]
// o_out    | out | valid/ready | kind[1:0], result_value[19:0]
// i_cfg    | in  | valid/ready | index[1:0], data[max(MOD_BITS,20)-1:0]
//
// A data word is registered straight into the output register; a new one is taken each cycle
// while the output register drains. Key wrap/unwrap runs the microprogram on the bit-serial
// modular multiplier. Input is held off while a key command runs and while a result waits
// unread. Reset (synchronous, active low) clears the sequencer, output valid, multiplier count,
// active key and configuration registers, with the modulus set to 2.
module rsa_wrapped_xor_cipher
    import rwx_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rwx_in_if.sink     i_in,
    rwx_out_if.source  o_out,
    rwx_cfg_if.sink    i_cfg
);

    localparam int CFG_W  = (MOD_BITS > VAL_W) ? MOD_BITS : VAL_W;
    localparam int MW     = MOD_BITS + 2;
    localparam int MCNT_W = $clog2(CFG_W + 1);

    // configuration
    logic [MOD_BITS-1:0] r_mod;
    logic [EXP_W-1:0]    r_enc_exp;
    logic [EXP_W-1:0]    r_dec_exp;
    logic [KEY_W-1:0]    r_session;

    // sequencer and datapath
    t_pc                 r_pc, n_pc;
    t_uword              uw;
    logic [KEY_W-1:0]    r_key;
    logic [CMD_W-1:0]    r_kind;
    logic [CFG_W-1:0]    r_raw;
    logic [EXP_W-1:0]    r_exp;
    logic [MOD_BITS-1:0] r_base;
    logic [MOD_BITS-1:0] r_acc;

    // modular multiplier
    logic [MOD_BITS-1:0] r_ma;
    logic [CFG_W-1:0]    r_mb;
    logic [MOD_BITS-1:0] r_macc, n_macc;
    logic [MCNT_W-1:0]   r_mcnt;
    logic                mbusy;

    // output register
    logic                r_o_valid;
    logic [CMD_W-1:0]    r_o_kind;
    logic [VAL_W-1:0]    r_o_value;

    logic [MOD_BITS-1:0] n_eff;
    logic                in_acc;
    logic                stall;
    logic                done_load;
    logic [MW-1:0]       mt;
    logic [MW-1:0]       mn1;
    logic [MW-1:0]       mn2;
    logic [CFG_W-1:0]    acc_ext;

    assign n_eff   = (r_mod < MOD_BITS'(2)) ? MOD_BITS'(2) : r_mod;
    assign uw      = ucode(r_pc);
    assign mbusy   = (r_mcnt != '0);
    assign acc_ext = CFG_W'(r_acc);

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_pc == UP_IDLE) && (!r_o_valid || o_out.ready);
    assign in_acc      = i_in.valid && i_in.ready;

    assign stall     = (uw.mwait && mbusy) || (uw.emit && r_o_valid && !o_out.ready);
    assign done_load = uw.emit && !stall;

    assign o_out.valid        = r_o_valid;
    assign o_out.kind         = r_o_kind;
    assign o_out.result_value = r_o_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod     <= MOD_BITS'(2);
            r_enc_exp <= '0;
            r_dec_exp <= '0;
            r_session <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_MODULUS:     r_mod     <= i_cfg.data[MOD_BITS-1:0];
                REG_ENC_EXP:     r_enc_exp <= i_cfg.data[EXP_W-1:0];
                REG_DEC_EXP:     r_dec_exp <= i_cfg.data[EXP_W-1:0];
                REG_SESSION_KEY: r_session <= i_cfg.data[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    // next step of the microprogram
    always_comb begin
        n_pc = r_pc;
        if (uw.dispatch) begin
            if (in_acc && (i_in.cmd == CMD_WRAP || i_in.cmd == CMD_UNWRAP)) begin
                n_pc = UP_RED;
            end
        end else if (!stall) begin
            case (uw.jcond)
                J_NEXT:     n_pc = t_pc'(r_pc + 4'd1);
                J_ALWAYS:   n_pc = uw.target;
                J_EXP_ZERO: n_pc = (r_exp == '0) ? uw.target : t_pc'(r_pc + 4'd1);
                J_EXP_EVEN: n_pc = (!r_exp[0]) ? uw.target : t_pc'(r_pc + 4'd1);
                default:    n_pc = UP_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // one multiplier bit per cycle: acc = 2*acc + bit*a, reduced from below 3n
    always_comb begin
        mt  = {1'b0, r_macc, 1'b0} + (r_mb[CFG_W-1] ? {2'b00, r_ma} : '0);
        mn1 = {2'b00, n_eff};
        mn2 = {1'b0, n_eff, 1'b0};
        if (mt >= mn2) begin
            n_macc = MOD_BITS'(mt - mn2);
        end else if (mt >= mn1) begin
            n_macc = MOD_BITS'(mt - mn1);
        end else begin
            n_macc = mt[MOD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
        end else if (uw.mstart) begin
            r_mcnt <= MCNT_W'(CFG_W);
        end else if (mbusy) begin
            r_mcnt <= r_mcnt - MCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.mstart) begin
            r_macc <= '0;
            case (uw.msel)
                MSEL_RED: begin
                    r_ma <= MOD_BITS'(1);
                    r_mb <= r_raw;
                end
                MSEL_ACC: begin
                    r_ma <= r_acc;
                    r_mb <= CFG_W'(r_base);
                end
                MSEL_SQR: begin
                    r_ma <= r_base;
                    r_mb <= CFG_W'(r_base);
                end
                default: begin
                    r_ma <= MOD_BITS'(1);
                    r_mb <= r_raw;
                end
            endcase
        end else if (mbusy) begin
            r_macc <= n_macc;
            r_mb   <= {r_mb[CFG_W-2:0], 1'b0};
        end
    end

    // operand and exponent registers
    always_ff @(posedge i_clk) begin
        if (uw.dispatch && in_acc) begin
            r_kind <= i_in.cmd;
            r_acc  <= MOD_BITS'(1);
            if (i_in.cmd == CMD_WRAP) begin
                r_raw <= CFG_W'(r_session);
                r_exp <= r_enc_exp;
            end else begin
                r_raw <= CFG_W'(i_in.value);
                r_exp <= r_dec_exp;
            end
        end else if (uw.mwait && !mbusy) begin
            case (uw.dest)
                DST_BASE: r_base <= r_macc;
                DST_ACC:  r_acc  <= r_macc;
                default: ;
            endcase
            if (uw.exp_shift) begin
                r_exp <= r_exp >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (uw.dispatch && in_acc && i_in.cmd == CMD_WRAP) begin
            r_key <= r_session;
        end else if (done_load && r_kind == CMD_UNWRAP) begin
            r_key <= r_acc[KEY_W-1:0];
        end
    end

    // output register: data words from dispatch, keys from the final step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((uw.dispatch && in_acc && i_in.cmd == CMD_DATA) || done_load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.dispatch && in_acc && i_in.cmd == CMD_DATA) begin
            r_o_kind  <= KIND_DATA;
            r_o_value <= VAL_W'(i_in.value[KEY_W-1:0] ^ r_key);
        end else if (done_load) begin
            if (r_kind == CMD_WRAP) begin
                r_o_kind  <= KIND_WRAPPED;
                r_o_value <= acc_ext[VAL_W-1:0];
            end else begin
                r_o_kind  <= KIND_RECOVERED;
                r_o_value <= VAL_W'(r_acc[KEY_W-1:0]);
            end
        end
    end

    a_key_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.cmd == CMD_WRAP || i_in.cmd == CMD_UNWRAP)) |=> (r_pc == UP_RED))
        else $error("key command did not start the microprogram");

    a_mul_busy_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mbusy |-> (r_pc == UP_RED_W || r_pc == UP_MUL_W || r_pc == UP_SQ_W))
        else $error("multiplier running outside a wait step");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc != UP_IDLE) |-> (r_acc < n_eff))
        else $error("accumulator not reduced below modulus");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_load |=> (r_o_valid && r_o_kind != KIND_DATA && r_pc == UP_IDLE))
        else $error("final step did not present a key result");

endmodule
`default_nettype wire

// ----- sim/rsa_wrapped_xor_cipher_tb.sv -----
`timescale 1ns / 100ps

module rsa_wrapped_xor_cipher_tb;
    import rwx_pkg::*;

    localparam int          CLK_HALF        = 6;
    localparam int          RESET_CYCLES    = 6;
    localparam int          CFG_SETTLE      = 32;
    localparam int          TAIL_CYCLES     = 64;
    localparam int          RAND_PHASES     = 8;
    localparam int          ITEMS_PER_PHASE = 103;
    localparam int unsigned CYCLE_LIMIT     = 1_500_000;
    localparam int          MAX_PRINTS      = 100;

    // cmd code 3 has no meaning; the block must drop it silently
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] kind;
        logic [VAL_W-1:0] value;
    } t_cipher_word;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op          op;
        logic [CMD_W-1:0] code;
        logic [VAL_W-1:0] data;
        bit               typed;
        logic [CMD_W-1:0] kind;
        logic [VAL_W-1:0] result;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    rwx_in_if                   in_if ();
    rwx_out_if                  out_if ();
    rwx_cfg_if #(.DATA_W(VAL_W)) cfg_if ();

    rsa_wrapped_xor_cipher #(.MOD_BITS(MOD_BITS_DEF)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // local copy of the block's registers and key state
    logic [VAL_W-1:0] cfg_modulus     = 20'd2;
    logic [EXP_W-1:0] cfg_enc_exp     = '0;
    logic [EXP_W-1:0] cfg_dec_exp     = '0;
    logic [KEY_W-1:0] cfg_session_key = '0;
    logic [KEY_W-1:0] act_key         = '0;
    logic [VAL_W-1:0] last_wrapped    = '0;

    t_cipher_word pending_out[$];
    t_cipher_word oldest;
    t_stim_row    stim_rows[$];

    int          tx_gap_pct   = 0;
    int          rx_stall_pct = 0;
    int          mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [VAL_W-1:0] pow_mod(input logic [VAL_W-1:0] base_in,
                                                 input logic [EXP_W-1:0] expo_in);
        longint unsigned n;
        longint unsigned b;
        longint unsigned acc;
        logic [EXP_W-1:0] e;
        n   = (cfg_modulus < VAL_W'(2)) ? 64'd2 : 64'(cfg_modulus);
        b   = 64'(base_in) % n;
        acc = 64'd1;
        e   = expo_in;
        while (e != 0) begin
            if (e[0])
                acc = (acc * b) % n;
            b = (b * b) % n;
            e = e >> 1;
        end
        return VAL_W'(acc % n);
    endfunction

    function automatic void predict_cipher(input logic [CMD_W-1:0] cmd,
                                           input logic [VAL_W-1:0] value,
                                           output bit produced,
                                           output logic [CMD_W-1:0] kind,
                                           output logic [VAL_W-1:0] result);
        logic [VAL_W-1:0] r;
        produced = 1'b1;
        kind     = '0;
        result   = '0;
        case (cmd)
            CMD_WRAP: begin
                act_key      = cfg_session_key;
                r            = pow_mod(VAL_W'(act_key), cfg_enc_exp);
                last_wrapped = r;
                kind         = KIND_WRAPPED;
                result       = r;
            end
            CMD_UNWRAP: begin
                r       = pow_mod(value, cfg_dec_exp);
                act_key = r[KEY_W-1:0];
                kind    = KIND_RECOVERED;
                result  = VAL_W'(act_key);
            end
            CMD_DATA: begin
                kind   = KIND_DATA;
                result = VAL_W'(value[KEY_W-1:0] ^ act_key);
            end
            default: produced = 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        if (mismatch_cnt < MAX_PRINTS)
            $display("MISMATCH %s at %0t: got 0x%05h, want 0x%05h", what, $realtime, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_out.size() == 0) begin
                report_mismatch("result word with nothing pending", out_if.result_value, '0);
            end else begin
                oldest = pending_out.pop_front();
                if (out_if.kind !== oldest.kind)
                    report_mismatch("kind", VAL_W'(out_if.kind), VAL_W'(oldest.kind));
                if (out_if.result_value !== oldest.value)
                    report_mismatch("result_value", out_if.result_value, oldest.value);
            end
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value,
                             input bit typed, input logic [CMD_W-1:0] t_kind,
                             input logic [VAL_W-1:0] t_val);
        bit               produced;
        logic [CMD_W-1:0] p_kind;
        logic [VAL_W-1:0] p_val;
        t_cipher_word     want;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd   <= cmd;
        in_if.value <= value;
        do @(posedge i_clk); while (!in_if.ready);
        predict_cipher(cmd, value, produced, p_kind, p_val);
        // a typed row overrides the predicted word but still advances the key state
        if (typed) begin
            p_kind   = t_kind;
            p_val    = t_val;
            produced = 1'b1;
        end
        want.kind  = p_kind;
        want.value = p_val;
        if (produced)
            pending_out.push_back(want);
    endtask

    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_MODULUS:     cfg_modulus     = data;
            REG_ENC_EXP:     cfg_enc_exp     = data;
            REG_DEC_EXP:     cfg_dec_exp     = data;
            REG_SESSION_KEY: cfg_session_key = data[KEY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void dir_item(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value,
                                     input bit typed, input logic [CMD_W-1:0] kind,
                                     input logic [VAL_W-1:0] result);
        t_stim_row row;
        row.op     = ROW_ITEM;
        row.code   = cmd;
        row.data   = value;
        row.typed  = typed;
        row.kind   = kind;
        row.result = result;
        stim_rows.push_back(row);
    endfunction

    function automatic void dir_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [VAL_W-1:0] data);
        t_stim_row row;
        row.op     = ROW_CFG;
        row.code   = idx;
        row.data   = data;
        row.typed  = 1'b0;
        row.kind   = '0;
        row.result = '0;
        stim_rows.push_back(row);
    endfunction

    initial begin
        int               ph;
        int               k;
        int               pick;
        logic [VAL_W-1:0] n_val;
        logic [EXP_W-1:0] e_val;
        logic [EXP_W-1:0] d_val;
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.cmd    = '0;
        in_if.value  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;

        // reset registers: modulus 2, both exponents 0, so every power is 1
        dir_item(CMD_WRAP,   20'h00000, 1, KIND_WRAPPED,   20'h00001);
        dir_item(CMD_UNWRAP, 20'hFFFFF, 1, KIND_RECOVERED, 20'h00001);
        dir_item(CMD_DATA,   20'h000FF, 1, KIND_DATA,      20'h000FE);
        dir_item(CMD_DATA,   20'hFFF00, 1, KIND_DATA,      20'h00001);
        dir_item(CMD_UNUSED, 20'hFFFFF, 0, KIND_DATA,      20'h00000);
        dir_item(CMD_DATA,   20'h00000, 1, KIND_DATA,      20'h00001);
        // all registers at their top value
        dir_reg(REG_MODULUS,     20'hFFFFF);
        dir_reg(REG_ENC_EXP,     20'hFFFFF);
        dir_reg(REG_DEC_EXP,     20'hFFFFF);
        dir_reg(REG_SESSION_KEY, 20'h000FF);
        dir_item(CMD_WRAP,   20'hFFFFF, 0, KIND_WRAPPED,   20'h00000);
        dir_item(CMD_DATA,   20'h00000, 1, KIND_DATA,      20'h000FF);
        dir_item(CMD_DATA,   20'hFFFFF, 1, KIND_DATA,      20'h00000);
        // wrapped value equal to the modulus reduces to zero
        dir_item(CMD_UNWRAP, 20'hFFFFF, 1, KIND_RECOVERED, 20'h00000);
        dir_item(CMD_UNWRAP, 20'h00000, 1, KIND_RECOVERED, 20'h00000);
        dir_item(CMD_UNWRAP, 20'h12345, 0, KIND_DATA,      20'h00000);
        dir_item(CMD_DATA,   20'h000A5, 0, KIND_DATA,      20'h00000);
        // textbook key pair: n = 61 * 53, e = 17, d = 2753; key data has junk high bits
        dir_reg(REG_MODULUS,     20'd3233);
        dir_reg(REG_ENC_EXP,     20'd17);
        dir_reg(REG_DEC_EXP,     20'd2753);
        dir_reg(REG_SESSION_KEY, 20'hFFF41);
        dir_item(CMD_WRAP,   20'h00000, 1, KIND_WRAPPED,   20'd2790);
        dir_item(CMD_UNWRAP, 20'd2790,  1, KIND_RECOVERED, 20'h00041);
        dir_item(CMD_UNWRAP, 20'd6023,  1, KIND_RECOVERED, 20'h00041);
        dir_item(CMD_UNWRAP, 20'd3000,  0, KIND_DATA,      20'h00000);
        dir_item(CMD_DATA,   20'h0003C, 0, KIND_DATA,      20'h00000);
        // modulus 1 and 0 behave as 2
        dir_reg(REG_MODULUS, 20'd1);
        dir_reg(REG_ENC_EXP, 20'd0);
        dir_item(CMD_WRAP,   20'h00000, 1, KIND_WRAPPED,   20'h00001);
        dir_reg(REG_MODULUS, 20'd0);
        dir_reg(REG_DEC_EXP, 20'd1);
        dir_item(CMD_UNWRAP, 20'd7,     1, KIND_RECOVERED, 20'h00001);
        dir_item(CMD_UNWRAP, 20'd6,     1, KIND_RECOVERED, 20'h00000);
        dir_item(CMD_DATA,   20'h00080, 1, KIND_DATA,      20'h00080);
        dir_item(CMD_UNUSED, 20'h00000, 0, KIND_DATA,      20'h00000);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].op == ROW_CFG) begin
                if (i == 0 || stim_rows[i-1].op == ROW_ITEM)
                    wait_idle(CFG_SETTLE);
                write_reg(stim_rows[i].code, stim_rows[i].data);
            end else begin
                send_item(stim_rows[i].code, stim_rows[i].data, stim_rows[i].typed,
                          stim_rows[i].kind, stim_rows[i].result);
            end
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle(CFG_SETTLE);
            case (ph % 4)
                0: begin
                    // matched key pairs, so wrap then unwrap round-trips the key mod n
                    case ($urandom_range(3))
                        0: begin n_val = 20'd3233; e_val = 20'd17; d_val = 20'd2753; end
                        1: begin n_val = 20'd143;  e_val = 20'd7;  d_val = 20'd103;  end
                        2: begin n_val = 20'd55;   e_val = 20'd3;  d_val = 20'd27;   end
                        default: begin n_val = 20'd77; e_val = 20'd7; d_val = 20'd43; end
                    endcase
                end
                1: begin
                    n_val = VAL_W'($urandom_range(2, 20'hFFFFF));
                    e_val = EXP_W'($urandom_range(0, 20'hFFFFF));
                    d_val = EXP_W'($urandom_range(0, 20'hFFFFF));
                end
                2: begin
                    n_val = VAL_W'($urandom_range(0, 300));
                    e_val = EXP_W'($urandom_range(0, 31));
                    d_val = EXP_W'($urandom_range(0, 1023));
                end
                default: begin
                    n_val = 20'hFFFFF - VAL_W'($urandom_range(0, 15));
                    e_val = (ph == 3) ? '0 : EXP_W'($urandom_range(0, 20'hFFFFF));
                    d_val = EXP_W'($urandom_range(0, 20'hFFFFF));
                end
            endcase
            write_reg(REG_MODULUS, n_val);
            write_reg(REG_ENC_EXP, e_val);
            write_reg(REG_DEC_EXP, d_val);
            write_reg(REG_SESSION_KEY, VAL_W'($urandom_range(0, 20'hFFFFF)));

            case (ph % 4)
                0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_gap_pct = 49; rx_stall_pct = 0;  end
                2:       begin tx_gap_pct = 0;  rx_stall_pct = 49; end
                default: begin tx_gap_pct = 28; rx_stall_pct = 28; end
            endcase

            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // hold the sender mid-phase until the output side has drained
                if (k == ITEMS_PER_PHASE / 2)
                    wait_idle(0);
                pick  = $urandom_range(99);
                value = VAL_W'($urandom_range(0, 20'hFFFFF));
                if (pick < 4) begin
                    cmd = CMD_UNUSED;
                end else if (pick < 10) begin
                    cmd = CMD_WRAP;
                end else if (pick < 18) begin
                    cmd = CMD_UNWRAP;
                    if ($urandom_range(1))
                        value = last_wrapped;
                end else begin
                    cmd = CMD_DATA;
                end
                send_item(cmd, value, 1'b0, KIND_DATA, '0);
            end
        end

        tx_gap_pct = 0;
        wait_idle(TAIL_CYCLES);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
